[rtl/ishs_pkg.sv]
// Shared types, constants and tables for the image source heat sum block.
package ishs_pkg;

  localparam int unsigned MAX_IMAGES = 64;
  localparam int unsigned IDX_W      = 6;   // width of the image_index field
  localparam int unsigned CNT_W      = 7;   // width of image_count
  localparam int unsigned TERM_W     = 31;  // Q1.30 exp term
  localparam int unsigned SUM_W      = TERM_W + $clog2(MAX_IMAGES + 1);

  localparam logic [30:0] LOG2E_Q30  = 31'd1549082005;
  localparam logic [21:0] X_CAP      = 22'(32 << 16);
  localparam logic [5:0]  XDIV_STEPS = 6'd22;
  localparam logic [5:0]  HDIV_STEPS = 6'd32;

  // configuration register indexes
  localparam logic [1:0] REG_ALPHA = 2'd0;
  localparam logic [1:0] REG_COEFF = 2'd1;
  localparam logic [1:0] REG_COUNT = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RSQ, ST_DMUL, ST_RD, ST_ZSQ, ST_XDIV_GO, ST_XDIV, ST_YMUL,
    ST_EXP, ST_ACC, ST_FIN, ST_NUM0, ST_NUM1, ST_HDIV_GO, ST_HDIV
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic wr_mem;
    logic emit_zero;
    logic load_pt;
    logic rsq;
    logic dmul;
    logic rd;
    logic zsq;
    logic xdiv_go;
    logic xdiv_take;
    logic ymul;
    logic exp_step;
    logic acc;
    logic den;
    logic num0;
    logic num1;
    logic hdiv_go;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_kind;
    logic in_tzero;
    logic n_zero;
    logic loop_last;
    logic exp_last;
    logic div_done;
    logic x_skip;
    logic sqrt_busy;
  } stat_t;

  // round(2^(-2^-(i+1)) * 2^30)
  function automatic logic [30:0] pow2_frac(input logic [3:0] i);
    logic [30:0] f;
    case (i)
      4'd0:    f = 31'd759250125;
      4'd1:    f = 31'd902905651;
      4'd2:    f = 31'd984625594;
      4'd3:    f = 31'd1028218693;
      4'd4:    f = 31'd1050733751;
      4'd5:    f = 31'd1062175491;
      4'd6:    f = 31'd1067942999;
      4'd7:    f = 31'd1070838486;
      4'd8:    f = 31'd1072289173;
      4'd9:    f = 31'd1073015252;
      4'd10:   f = 31'd1073378477;
      4'd11:   f = 31'd1073560135;
      4'd12:   f = 31'd1073650976;
      4'd13:   f = 31'd1073696399;
      4'd14:   f = 31'd1073719111;
      4'd15:   f = 31'd1073730468;
      default: f = 31'd0;
    endcase
    return f;
  endfunction

endpackage

[rtl/image_source_heat_sum_unit.sv]
// Top level of the image source heat sum block: controller plus datapath.
//
// Usage: raise start_i with a word on the input ports; it is taken at an edge
// where busy_o is low. kind_i low stores depth_value_i in slot image_index_i,
// with no result. kind_i high evaluates the point (radius_scaled_i,
// time_value_i) and yields one result word, shown for one cycle with
// result_valid_o high. A zero time gives its result (time_zero_o set,
// heat_value_o zero) in the cycle after the start. Otherwise the loop runs
// over N depths, N being the clamped image_count: each depth takes a pass of
// the shared bit-serial divider and then the exp table multiplier, which is
// skipped when the term vanishes. The sqrt of t runs in parallel with the
// loop. A final pass of the same divider gives the scaled result. One
// evaluation is in flight at a time; busy_o drops as the result shows, so the
// next word can be taken then.
// Configuration writes (cfg_we_i, cfg_index_i, cfg_wdata_i) take effect at
// once and belong in idle time. Reset restores register defaults; the depth
// table holds nothing valid until written. Results cannot be stalled.
module image_source_heat_sum_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic                       kind_i,
  input  logic [ishs_pkg::IDX_W-1:0] image_index_i,
  input  logic signed [23:0]         depth_value_i,
  input  logic [23:0]                radius_scaled_i,
  input  logic [31:0]                time_value_i,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_index_i,
  input  logic [31:0]                cfg_wdata_i,
  output logic                       result_valid_o,
  output logic [31:0]                heat_value_o,
  output logic                       time_zero_o,
  output logic                       saturated_o
);

  ishs_pkg::cmd_t  cmd;
  ishs_pkg::stat_t stat;

  ishs_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  ishs_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .kind_i          (kind_i),
    .image_index_i   (image_index_i),
    .depth_value_i   (depth_value_i),
    .radius_scaled_i (radius_scaled_i),
    .time_value_i    (time_value_i),
    .heat_value_o    (heat_value_o),
    .time_zero_o     (time_zero_o),
    .saturated_o     (saturated_o),
    .result_valid_o  (result_valid_o)
  );

endmodule

[rtl/ishs_div.sv]
// Shared restoring divider: one quotient bit per cycle, with overflow check.
module ishs_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] hi_i,
  input  logic [31:0] lo_i,
  input  logic [5:0]  steps_i,
  input  logic [63:0] divisor_i,
  output logic        done_o,
  output logic        over_o,
  output logic [31:0] quot_o
);

  logic        busy_q, done_q, over_q;
  logic [5:0]  cnt_q;
  logic [63:0] rem_q, dvs_q;
  logic [31:0] lo_q, quot_q;
  logic [64:0] trial;
  logic        qbit;

  // one shift-subtract step
  always_comb begin
    trial = {rem_q, lo_q[31]};
    qbit  = (trial >= {1'b0, dvs_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // quotient overflows when the high part already reaches the divisor
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= hi_i;
      lo_q   <= lo_i;
      dvs_q  <= divisor_i;
      over_q <= (hi_i >= divisor_i);
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= qbit ? 64'(trial - {1'b0, dvs_q}) : trial[63:0];
      lo_q   <= {lo_q[30:0], 1'b0};
      quot_q <= {quot_q[30:0], qbit};
    end
  end

  assign done_o = done_q;
  assign over_o = over_q;
  assign quot_o = quot_q;

endmodule

[rtl/ishs_ctrl.sv]
// Sequencing state machine for depth writes and point evaluations.
module ishs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  ishs_pkg::stat_t stat_i,
  output ishs_pkg::cmd_t  cmd_o,
  output logic           busy_o
);

  ishs_pkg::state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ishs_pkg::ST_IDLE:
        if (start_i && stat_i.in_kind && !stat_i.in_tzero) state_d = ishs_pkg::ST_RSQ;
      ishs_pkg::ST_RSQ:  state_d = ishs_pkg::ST_DMUL;
      ishs_pkg::ST_DMUL: state_d = stat_i.n_zero ? ishs_pkg::ST_FIN : ishs_pkg::ST_RD;
      ishs_pkg::ST_RD:   state_d = ishs_pkg::ST_ZSQ;
      ishs_pkg::ST_ZSQ:  state_d = ishs_pkg::ST_XDIV_GO;
      ishs_pkg::ST_XDIV_GO: state_d = ishs_pkg::ST_XDIV;
      ishs_pkg::ST_XDIV:
        if (stat_i.div_done) state_d = stat_i.x_skip ? ishs_pkg::ST_ACC : ishs_pkg::ST_YMUL;
      ishs_pkg::ST_YMUL: state_d = ishs_pkg::ST_EXP;
      ishs_pkg::ST_EXP:  if (stat_i.exp_last) state_d = ishs_pkg::ST_ACC;
      ishs_pkg::ST_ACC:  state_d = stat_i.loop_last ? ishs_pkg::ST_FIN : ishs_pkg::ST_RD;
      ishs_pkg::ST_FIN:  if (!stat_i.sqrt_busy) state_d = ishs_pkg::ST_NUM0;
      ishs_pkg::ST_NUM0: state_d = ishs_pkg::ST_NUM1;
      ishs_pkg::ST_NUM1: state_d = ishs_pkg::ST_HDIV_GO;
      ishs_pkg::ST_HDIV_GO: state_d = ishs_pkg::ST_HDIV;
      ishs_pkg::ST_HDIV: if (stat_i.div_done) state_d = ishs_pkg::ST_IDLE;
      default: state_d = ishs_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o = '0;
    case (state_q)
      ishs_pkg::ST_IDLE: begin
        cmd_o.wr_mem    = start_i && !stat_i.in_kind;
        cmd_o.emit_zero = start_i && stat_i.in_kind && stat_i.in_tzero;
        cmd_o.load_pt   = start_i && stat_i.in_kind && !stat_i.in_tzero;
      end
      ishs_pkg::ST_RSQ:     cmd_o.rsq      = 1'b1;
      ishs_pkg::ST_DMUL:    cmd_o.dmul     = 1'b1;
      ishs_pkg::ST_RD:      cmd_o.rd       = 1'b1;
      ishs_pkg::ST_ZSQ:     cmd_o.zsq      = 1'b1;
      ishs_pkg::ST_XDIV_GO: cmd_o.xdiv_go  = 1'b1;
      ishs_pkg::ST_XDIV:    cmd_o.xdiv_take = stat_i.div_done;
      ishs_pkg::ST_YMUL:    cmd_o.ymul     = 1'b1;
      ishs_pkg::ST_EXP:     cmd_o.exp_step = 1'b1;
      ishs_pkg::ST_ACC:     cmd_o.acc      = 1'b1;
      ishs_pkg::ST_FIN:     cmd_o.den      = !stat_i.sqrt_busy;
      ishs_pkg::ST_NUM0:    cmd_o.num0     = 1'b1;
      ishs_pkg::ST_NUM1:    cmd_o.num1     = 1'b1;
      ishs_pkg::ST_HDIV_GO: cmd_o.hdiv_go  = 1'b1;
      ishs_pkg::ST_HDIV:    cmd_o.emit     = stat_i.div_done;
      default:              cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ishs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ishs_pkg::ST_IDLE);

endmodule

[rtl/ishs_dpath.sv]
// Datapath: config registers, depth memory, sqrt, exp and shared divider.
module ishs_dpath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ishs_pkg::cmd_t               cmd_i,
  output ishs_pkg::stat_t              stat_o,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_index_i,
  input  logic [31:0]                  cfg_wdata_i,
  input  logic                         kind_i,
  input  logic [ishs_pkg::IDX_W-1:0]   image_index_i,
  input  logic signed [23:0]           depth_value_i,
  input  logic [23:0]                  radius_scaled_i,
  input  logic [31:0]                  time_value_i,
  output logic [31:0]                  heat_value_o,
  output logic                         time_zero_o,
  output logic                         saturated_o,
  output logic                         result_valid_o
);

  // configuration
  logic [31:0] alpha_q, coeff_q;
  logic [ishs_pkg::CNT_W-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= 32'd16777216;
      coeff_q <= 32'd65536;
      count_q <= 7'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ishs_pkg::REG_ALPHA: alpha_q <= cfg_wdata_i;
        ishs_pkg::REG_COEFF: coeff_q <= cfg_wdata_i;
        ishs_pkg::REG_COUNT: count_q <= cfg_wdata_i[ishs_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // depth memory
  logic [23:0] mem [ishs_pkg::MAX_IMAGES];
  logic [23:0] z_q;
  logic [ishs_pkg::CNT_W-1:0] idx_q, n_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_mem && ({1'b0, image_index_i} < ishs_pkg::CNT_W'(ishs_pkg::MAX_IMAGES))) begin
      mem[image_index_i] <= depth_value_i;
    end
    if (cmd_i.rd) begin
      z_q <= mem[idx_q[ishs_pkg::IDX_W-1:0]];
    end
  end

  // point setup
  logic [23:0] r_q;
  logic [31:0] t_q;
  logic [47:0] rr_q;
  logic [63:0] d_q;
  logic [48:0] r2_q;
  logic [23:0] zm;

  assign zm = z_q[23] ? 24'(24'd0 - z_q) : z_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pt) begin
      r_q <= radius_scaled_i;
      t_q <= time_value_i;
    end
    if (cmd_i.rsq)  rr_q <= r_q * r_q;
    if (cmd_i.dmul) d_q  <= ((alpha_q != 32'd0) ? alpha_q : 32'd1) * t_q;
    if (cmd_i.zsq)  r2_q <= 49'(rr_q) + (49'(zm) * 49'(zm));
  end

  // image loop counter; count clamped to the table size
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      n_q   <= '0;
    end else if (cmd_i.load_pt) begin
      idx_q <= '0;
      n_q   <= (count_q > ishs_pkg::CNT_W'(ishs_pkg::MAX_IMAGES)) ?
               ishs_pkg::CNT_W'(ishs_pkg::MAX_IMAGES) : count_q;
    end else if (cmd_i.acc) begin
      idx_q <= idx_q + 7'd1;
    end
  end

  // shared divider
  logic        div_go, div_done, div_over;
  logic [63:0] div_hi, div_dvs;
  logic [31:0] div_lo, div_quot;
  logic [5:0]  div_steps;
  logic [69:0] num_q;
  logic [63:0] den_q;

  always_comb begin
    div_go    = cmd_i.xdiv_go || cmd_i.hdiv_go;
    div_hi    = cmd_i.hdiv_go ? 64'(num_q[69:22]) : 64'(r2_q);
    div_lo    = cmd_i.hdiv_go ? {num_q[21:0], 10'd0} : 32'd0;
    div_steps = cmd_i.hdiv_go ? ishs_pkg::HDIV_STEPS : ishs_pkg::XDIV_STEPS;
    div_dvs   = cmd_i.hdiv_go ? den_q : d_q;
  end

  ishs_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_go),
    .hi_i      (div_hi),
    .lo_i      (div_lo),
    .steps_i   (div_steps),
    .divisor_i (div_dvs),
    .done_o    (div_done),
    .over_o    (div_over),
    .quot_o    (div_quot)
  );

  logic x_skip;
  assign x_skip = div_over || (div_quot[21:0] > ishs_pkg::X_CAP);

  // exp2 of the negated exponent, one table factor per cycle
  logic [21:0] x_q, y_q;
  logic        skip_q;
  logic [30:0] v_q;
  logic [3:0]  k_q;
  logic [52:0] yprod;
  logic [61:0] vprod;
  logic [5:0]  ysh;
  logic [30:0] term;
  logic [ishs_pkg::SUM_W-1:0] sum_q;

  assign yprod = (53'(x_q) * 53'(ishs_pkg::LOG2E_Q30)) + 53'(1 << 29);
  assign vprod = (62'(v_q) * 62'(ishs_pkg::pow2_frac(k_q))) + 62'(1 << 29);
  assign ysh   = y_q[21:16];
  assign term  = (ysh >= 6'd31) ? 31'd0 : (v_q >> ysh);

  always_ff @(posedge clk_i) begin
    if (cmd_i.xdiv_take) begin
      x_q    <= div_quot[21:0];
      skip_q <= x_skip;
    end
    if (cmd_i.ymul) begin
      y_q <= yprod[51:30];
      v_q <= 31'(1 << 30);
      k_q <= '0;
    end
    if (cmd_i.exp_step) begin
      if (y_q[4'd15 - k_q]) v_q <= vprod[60:30];
      k_q <= k_q + 4'd1;
    end
    if (cmd_i.load_pt) begin
      sum_q <= '0;
    end else if (cmd_i.acc && !skip_q) begin
      sum_q <= sum_q + ishs_pkg::SUM_W'(term);
    end
  end

  // sqrt of t * 2^32, two radicand bits per cycle, runs beside the loop
  logic        sq_busy_q;
  logic [5:0]  sq_cnt_q;
  logic [31:0] sq_v_q, sq_res_q;
  logic [34:0] sq_rem_q, sq_remx, sq_trial;

  assign sq_remx  = {sq_rem_q[32:0], sq_v_q[31:30]};
  assign sq_trial = {1'b0, sq_res_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_busy_q <= 1'b0;
      sq_cnt_q  <= '0;
    end else if (cmd_i.load_pt) begin
      sq_busy_q <= 1'b1;
      sq_cnt_q  <= 6'd32;
    end else if (sq_busy_q) begin
      sq_cnt_q <= sq_cnt_q - 6'd1;
      if (sq_cnt_q == 6'd1) sq_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pt) begin
      sq_v_q   <= time_value_i;
      sq_res_q <= '0;
      sq_rem_q <= '0;
    end else if (sq_busy_q) begin
      sq_v_q <= {sq_v_q[29:0], 2'b00};
      if (sq_remx >= sq_trial) begin
        sq_rem_q <= sq_remx - sq_trial;
        sq_res_q <= {sq_res_q[30:0], 1'b1};
      end else begin
        sq_rem_q <= sq_remx;
        sq_res_q <= {sq_res_q[30:0], 1'b0};
      end
    end
  end

  // final scaling: coeff * sum * 2^10 over t * sqrt(t * 2^32)
  logic [63:0] plo_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.den)  den_q <= t_q * sq_res_q;
    if (cmd_i.num0) plo_q <= coeff_q * sum_q[31:0];
    if (cmd_i.num1) begin
      num_q <= 70'(plo_q) +
               ((70'(coeff_q) * 70'(sum_q[ishs_pkg::SUM_W-1:32])) << 32);
    end
  end

  // result word
  logic        valid_q;
  logic [31:0] heat_q;
  logic        tz_q, sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit || cmd_i.emit_zero;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_zero) begin
      heat_q <= '0;
      tz_q   <= 1'b1;
      sat_q  <= 1'b0;
    end else if (cmd_i.emit) begin
      heat_q <= div_over ? 32'hFFFF_FFFF : div_quot;
      tz_q   <= 1'b0;
      sat_q  <= div_over;
    end
  end

  assign heat_value_o   = heat_q;
  assign time_zero_o    = tz_q;
  assign saturated_o    = sat_q;
  assign result_valid_o = valid_q;

  // status
  always_comb begin
    stat_o           = '0;
    stat_o.in_kind   = kind_i;
    stat_o.in_tzero  = (time_value_i == 32'd0);
    stat_o.n_zero    = (n_q == '0);
    stat_o.loop_last = ((idx_q + 7'd1) == n_q);
    stat_o.exp_last  = (k_q == 4'd15);
    stat_o.div_done  = div_done;
    stat_o.x_skip    = x_skip;
    stat_o.sqrt_busy = sq_busy_q;
  end

endmodule
